>>> hdl/sha_pkg.sv
// Package for the streaming SHA-256 hasher: round constants, initial hash values
// and the round helper functions. No dependencies.
`default_nettype none
package sha_pkg;
    localparam int DIGEST_WORDS = 8;

    typedef logic [31:0] word_t;

    function automatic word_t rotr(input word_t v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic word_t init_hash(input logic [2:0] idx);
        case (idx)
            3'd0: init_hash = 32'h6a09e667;
            3'd1: init_hash = 32'hbb67ae85;
            3'd2: init_hash = 32'h3c6ef372;
            3'd3: init_hash = 32'ha54ff53a;
            3'd4: init_hash = 32'h510e527f;
            3'd5: init_hash = 32'h9b05688c;
            3'd6: init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic word_t round_k(input logic [5:0] r);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        round_k = k[r];
    endfunction
endpackage
`default_nettype wire

>>> hdl/sha_round.sv
// One SHA-256 round and one message schedule step, reused for all 64 rounds.
// Depends on sha_pkg.
`default_nettype none
module sha_round
    import sha_pkg::*;
(
    input  wire word_t       a,
    input  wire word_t       b,
    input  wire word_t       c,
    input  wire word_t       d,
    input  wire word_t       e,
    input  wire word_t       f,
    input  wire word_t       g,
    input  wire word_t       h,
    input  wire word_t       k,
    input  wire word_t       w,
    input  wire word_t       w2,
    input  wire word_t       w7,
    input  wire word_t       w15,
    input  wire word_t       w16,
    output word_t            new_a,
    output word_t            new_e,
    output word_t            new_w
);
    word_t t1;
    word_t t2;
    word_t s0;
    word_t s1;

    // Compression round.
    always_comb
    begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + k + w;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        new_a = t1 + t2;
        new_e = d + t1;
    end

    // Schedule expansion.
    always_comb
    begin
        s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        new_w = s1 + w7 + s0 + w16;
    end
endmodule
`default_nettype wire

>>> hdl/sha256_stream_hasher.sv
// Top level of the streaming SHA-256 hasher: byte packer, padding sequencer,
// schedule window and the shared round unit. Depends on sha_pkg and sha_round.
//
//  channel | dir | tdata                         | tuser        | tlast
//  s_axis  | in  | data_word[31:0]               | byte_count   | end_of_message
//  m_axis  | out | digest_word[31:0]             | word_index   | last_word
//
// A request is taken, then its bytes (0 to 4) are written one by one into the block window,
// and the input stays stalled until the last of them is written. Writing byte 63 of a block
// starts the 64 rounds of the shared round unit, followed by an add into the hash. A final
// request then writes the 0x80 mark, zero bytes up to byte 56 and the length, runs one or
// two such compressions, and offers eight digest words, each held until it is taken.
// Reset (asynchronous, active low) loads the initial hash and clears the length.
// The input is stalled whenever the sequencer is not idle.
`default_nettype none
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // data_word[31:0]
    input  wire  [2:0]  s_axis_tuser,   // byte_count[2:0]
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word[31:0]
    output logic [2:0]  m_axis_tuser,   // word_index[2:0]
    output logic        m_axis_tlast
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BYTE = 3'd1;
    localparam logic [2:0] ST_MARK = 3'd2;
    localparam logic [2:0] ST_ZERO = 3'd3;
    localparam logic [2:0] ST_COMP = 3'd4;
    localparam logic [2:0] ST_ADD  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]  state_reg, state_next;
    word_t       hash_reg [DIGEST_WORDS];
    word_t       v_reg [8];
    word_t       win_reg [16];
    logic [63:0] len_reg;
    logic [5:0]  fill_reg;    // next byte position in the block
    logic [31:0] data_reg;
    logic [2:0]  cnt_reg;
    logic        last_reg;
    logic        pad_reg;     // padding mark already placed
    logic        final_reg;   // this block carries the length
    logic [5:0]  round_reg;
    logic [2:0]  out_reg;
    word_t       new_a, new_e, new_w;
    word_t       k_word;
    logic [3:0]  wsel;
    logic [4:0]  lane;

    assign wsel   = fill_reg[5:2];
    assign lane   = {~fill_reg[1:0], 3'b000};
    assign k_word = round_k(round_reg);

    sha_round u_round (
        .a(v_reg[0]), .b(v_reg[1]), .c(v_reg[2]), .d(v_reg[3]),
        .e(v_reg[4]), .f(v_reg[5]), .g(v_reg[6]), .h(v_reg[7]),
        .k(k_word), .w(win_reg[0]),
        .w2(win_reg[14]), .w7(win_reg[9]), .w15(win_reg[1]), .w16(win_reg[0]),
        .new_a(new_a), .new_e(new_e), .new_w(new_w)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = hash_reg[out_reg];
    assign m_axis_tuser  = out_reg;
    assign m_axis_tlast  = (out_reg == 3'd7);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser != 3'd0)
                        state_next = ST_BYTE;
                    else if (s_axis_tlast)
                        state_next = ST_MARK;
                end
            ST_BYTE:
                if (fill_reg == 6'd63)
                    state_next = ST_COMP;
                else if (cnt_reg == 3'd1)
                    state_next = last_reg ? ST_MARK : ST_IDLE;
            ST_MARK:
                state_next = (fill_reg == 6'd63) ? ST_COMP : ST_ZERO;
            ST_ZERO:
                if (fill_reg == 6'd56 || fill_reg == 6'd63)
                    state_next = ST_COMP;
            ST_COMP:
                if (round_reg == 6'd63)
                    state_next = ST_ADD;
            ST_ADD:
                if (final_reg)
                    state_next = ST_OUT;
                else if (cnt_reg != 3'd0)
                    state_next = ST_BYTE;
                else if (pad_reg)
                    state_next = ST_ZERO;
                else if (last_reg)
                    state_next = ST_MARK;
                else
                    state_next = ST_IDLE;
            ST_OUT:
                if (m_axis_tready && out_reg == 3'd7)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            fill_reg  <= '0;
            data_reg  <= '0;
            round_reg <= '0;
            out_reg   <= '0;
            pad_reg   <= 1'b0;
            final_reg <= 1'b0;
            last_reg  <= 1'b0;
            cnt_reg   <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++) hash_reg[i] <= init_hash(3'(i));
            for (int i = 0; i < 8; i++) v_reg[i] <= '0;
            for (int i = 0; i < 16; i++) win_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                    if (s_axis_tvalid)
                    begin
                        data_reg  <= s_axis_tdata;
                        cnt_reg   <= (s_axis_tuser > 3'd4) ? 3'd4 : s_axis_tuser;
                        last_reg  <= s_axis_tlast;
                        pad_reg   <= 1'b0;
                        final_reg <= 1'b0;
                    end
                ST_BYTE:
                begin
                    // One message byte per cycle, top byte first.
                    win_reg[wsel][lane +: 8] <= data_reg[31:24];
                    data_reg <= {data_reg[23:0], 8'h00};
                    cnt_reg  <= cnt_reg - 3'd1;
                    len_reg  <= len_reg + 64'd8;
                    fill_reg <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                        for (int i = 0; i < 8; i++) v_reg[i] <= hash_reg[i];
                end
                ST_MARK:
                begin
                    // The 0x80 mark follows the last message byte.
                    win_reg[wsel][lane +: 8] <= 8'h80;
                    pad_reg  <= 1'b1;
                    fill_reg <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                        for (int i = 0; i < 8; i++) v_reg[i] <= hash_reg[i];
                end
                ST_ZERO:
                    if (fill_reg == 6'd56)
                    begin
                        // The bit length fills the last two words of the final block.
                        win_reg[14] <= len_reg[63:32];
                        win_reg[15] <= len_reg[31:0];
                        final_reg   <= 1'b1;
                        fill_reg    <= '0;
                        for (int i = 0; i < 8; i++) v_reg[i] <= hash_reg[i];
                    end
                    else
                    begin
                        win_reg[wsel][lane +: 8] <= 8'h00;
                        fill_reg <= fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                            for (int i = 0; i < 8; i++) v_reg[i] <= hash_reg[i];
                    end
                ST_COMP:
                begin
                    v_reg[0] <= new_a;
                    v_reg[1] <= v_reg[0];
                    v_reg[2] <= v_reg[1];
                    v_reg[3] <= v_reg[2];
                    v_reg[4] <= new_e;
                    v_reg[5] <= v_reg[4];
                    v_reg[6] <= v_reg[5];
                    v_reg[7] <= v_reg[6];
                    for (int i = 0; i < 15; i++) win_reg[i] <= win_reg[i + 1];
                    win_reg[15] <= new_w;
                    round_reg <= round_reg + 6'd1;
                end
                ST_ADD:
                    for (int i = 0; i < DIGEST_WORDS; i++)
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                ST_OUT:
                    if (m_axis_tready)
                    begin
                        out_reg <= out_reg + 3'd1;
                        if (out_reg == 3'd7)
                        begin
                            for (int i = 0; i < DIGEST_WORDS; i++)
                                hash_reg[i] <= init_hash(3'(i));
                            len_reg <= '0;
                        end
                    end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hdl/sha_checker.sv
// Port-level checks for the streaming SHA-256 hasher, bound to the top level.
// Depends on sha256_stream_hasher.
`default_nettype none
module sha_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [2:0]  m_axis_tuser,
    input wire        m_axis_tlast
);
    // The input is never taken while a digest is on offer.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready during output");
    // tlast marks word seven only.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7))) else $error("tlast");
    // Words advance by one after each taken word but the last.
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1) else $error("order");
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
